// ===== design/srat_pkg.sv =====
`default_nettype none
package srat_pkg;

    localparam int BUF_BYTES_DEF = 65536;

    typedef enum logic [1:0] {
        ACT_NONE   = 2'd0,
        ACT_ACK    = 2'd1,
        ACT_RESEND = 2'd2
    } action_t;

    localparam logic CMD_DATA = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    localparam logic [1:0] REG_RESEND_TIMEOUT = 2'd0;
    localparam logic [1:0] REG_EXPECTED_MAGIC = 2'd1;
    localparam logic [1:0] REG_DATA_FLAG_CODE = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PROC,
        ST_CHK,
        ST_MARK,
        ST_SCAN0,
        ST_SCAN,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic        cmd;
        logic [31:0] seq_num;
        logic [15:0] seg_len;
        logic [31:0] magic_value;
        logic [7:0]  seg_flags;
        logic [63:0] now_ticks;
    } in_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [16:0] ack_seq;
        logic        store_payload;
        logic [16:0] in_order_end;
    } out_t;

endpackage
`default_nettype wire

// ===== design/srat_ram.sv =====
`default_nettype none
module srat_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ===== design/stream_reassembly_ack_tracker_top.sv =====
// receive-side segment tracker with cumulative acknowledgement
// input channel s_valid/s_ready/s_data carries a data segment header or a timer tick
// result channel m_valid/m_ready/m_data gives exactly one result per input transaction
// configuration channel cfg_valid/cfg_ready/cfg_index/cfg_data writes the three registers
// (index 0 resend timeout, 1 expected magic, 2 data flag code); cfg_ready is always high
// one item is processed at a time: a tick, bad header or old segment goes from ST_PROC
// straight to ST_FIN, and the next item is accepted once its result is registered
// a segment that fits passes ST_CHK, ST_MARK for each bitmap word it marks, and ST_SCAN0,
// plus ST_SCAN for each bitmap word walked when it starts at the next expected byte
// the received bitmap lives in one ram of (BUF_BYTES+63)/64 words of 64 bits with
// registered read; each word a segment marks is read, or-ed and written back by the sequencer
// after reset a clearing pass writes zero to every bitmap word, one word per cycle,
// while s_ready stays low
// a finished result sits in the output register; the next item is accepted while it
// waits, but that item is not finished until the receiver takes the earlier result
`default_nettype none
module stream_reassembly_ack_tracker_top #(
    parameter int BUF_BYTES = srat_pkg::BUF_BYTES_DEF
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire srat_pkg::in_t   s_data,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output srat_pkg::out_t       m_data,
    input  wire logic            cfg_valid,
    output logic                 cfg_ready,
    input  wire logic [1:0]      cfg_index,
    input  wire logic [63:0]     cfg_data
);

    localparam int WORDS = (BUF_BYTES + 63) / 64;
    localparam int AW    = $clog2(WORDS);
    localparam int NE_W  = $clog2(WORDS * 64 + 1);

    srat_pkg::state_t state_reg, state_next;

    logic [63:0]     timeout_reg;
    logic [31:0]     magic_reg;
    logic [7:0]      flag_reg;

    srat_pkg::in_t   item_reg;
    logic [NE_W-1:0] ne_reg, ne_next;
    logic [32:0]     he_reg, he_next;
    logic [63:0]     lp_reg, lp_next;
    logic [63:0]     lr_reg, lr_next;
    logic            hs_reg, hs_next;
    logic [1:0]      action_reg, action_next;
    logic            store_reg, store_next;
    logic [AW-1:0]   word_reg, word_next;
    logic [AW-1:0]   last_reg, last_next;
    logic [AW-1:0]   clr_reg, clr_next;
    srat_pkg::out_t  out_reg;
    logic            m_valid_reg;

    logic            ram_we, ram_re;
    logic [AW-1:0]   ram_waddr, ram_raddr;
    logic [63:0]     ram_wdata, ram_rdata;

    logic [32:0]     seg_end, seg_endm1;
    logic            hdr_ok, seg_old, seg_fits, at_next, first_marked;
    logic [AW-1:0]   seq_word;
    logic [5:0]      lo_bit, hi_bit;
    logic [63:0]     mark_mask;
    logic [5:0]      ne_off;
    logic [63:0]     scan_inv;
    logic [6:0]      ones_cnt;
    logic            out_free;

    srat_ram #(.WIDTH(64), .DEPTH(WORDS)) u_map (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_ready   = (state_reg == srat_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = out_reg;
    assign out_free  = !m_valid_reg || m_ready;

    assign seg_end      = {1'b0, item_reg.seq_num} + 33'(item_reg.seg_len);
    assign seg_endm1    = seg_end - 33'd1;
    assign hdr_ok       = (item_reg.magic_value == magic_reg) && (item_reg.seg_flags == flag_reg);
    assign seg_old      = {1'b0, item_reg.seq_num} < 33'(ne_reg);
    assign seg_fits     = seg_end < 33'(BUF_BYTES);
    assign at_next      = {1'b0, item_reg.seq_num} == 33'(ne_reg);
    assign seq_word     = item_reg.seq_num[AW+5:6];
    assign first_marked = ram_rdata[item_reg.seq_num[5:0]];
    assign lo_bit       = (word_reg == seq_word) ? item_reg.seq_num[5:0] : 6'd0;
    assign hi_bit       = (word_reg == last_reg) ? seg_endm1[5:0] : 6'd63;
    assign mark_mask    = ({64{1'b1}} << lo_bit) & ({64{1'b1}} >> (6'd63 - hi_bit));
    assign ne_off       = ne_reg[5:0];
    assign scan_inv     = ~(ram_rdata >> ne_off);

    always_comb begin
        ones_cnt = 7'd64;
        for (int i = 63; i >= 0; i--) begin
            if (scan_inv[i]) begin
                ones_cnt = 7'(i);
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            srat_pkg::ST_CLEAR: begin
                if (clr_reg == AW'(WORDS - 1)) begin
                    state_next = srat_pkg::ST_IDLE;
                end
            end
            srat_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = srat_pkg::ST_PROC;
                end
            end
            srat_pkg::ST_PROC: begin
                if (item_reg.cmd == srat_pkg::CMD_DATA && hdr_ok && !seg_old && seg_fits) begin
                    state_next = srat_pkg::ST_CHK;
                end else begin
                    state_next = srat_pkg::ST_FIN;
                end
            end
            srat_pkg::ST_CHK: begin
                if (!first_marked && item_reg.seg_len != 16'd0) begin
                    state_next = srat_pkg::ST_MARK;
                end else begin
                    state_next = srat_pkg::ST_SCAN0;
                end
            end
            srat_pkg::ST_MARK: begin
                if (word_reg == last_reg) begin
                    state_next = srat_pkg::ST_SCAN0;
                end
            end
            srat_pkg::ST_SCAN0: begin
                if (at_next && ne_reg < NE_W'(BUF_BYTES)) begin
                    state_next = srat_pkg::ST_SCAN;
                end else begin
                    state_next = srat_pkg::ST_FIN;
                end
            end
            srat_pkg::ST_SCAN: begin
                if (ones_cnt != 7'd64 - 7'(ne_off) ||
                    ((NE_W'(word_reg) + NE_W'(1)) << 6) >= NE_W'(BUF_BYTES)) begin
                    state_next = srat_pkg::ST_FIN;
                end
            end
            srat_pkg::ST_FIN: begin
                if (out_free) begin
                    state_next = srat_pkg::ST_IDLE;
                end
            end
            default: state_next = srat_pkg::ST_CLEAR;
        endcase
    end

    always_comb begin
        ne_next     = ne_reg;
        he_next     = he_reg;
        lp_next     = lp_reg;
        lr_next     = lr_reg;
        hs_next     = hs_reg;
        action_next = action_reg;
        store_next  = store_reg;
        word_next   = word_reg;
        last_next   = last_reg;
        clr_next    = clr_reg;
        ram_we      = 1'b0;
        ram_waddr   = word_reg;
        ram_wdata   = ram_rdata | mark_mask;
        ram_re      = 1'b0;
        ram_raddr   = word_reg + AW'(1);
        case (state_reg)
            srat_pkg::ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = 64'd0;
                clr_next  = clr_reg + AW'(1);
            end
            srat_pkg::ST_IDLE: begin
                action_next = srat_pkg::ACT_NONE;
                store_next  = 1'b0;
            end
            srat_pkg::ST_PROC: begin
                if (item_reg.cmd == srat_pkg::CMD_TICK) begin
                    if (hs_reg && 33'(ne_reg) < he_reg &&
                        (item_reg.now_ticks - lp_reg) > timeout_reg &&
                        (item_reg.now_ticks - lr_reg) > timeout_reg) begin
                        action_next = srat_pkg::ACT_RESEND;
                        lr_next     = item_reg.now_ticks;
                    end
                end else if (hdr_ok) begin
                    if (!hs_reg) begin
                        hs_next = 1'b1;
                        lp_next = item_reg.now_ticks;
                    end
                    if (seg_end > he_reg) begin
                        he_next = seg_end;
                    end
                    if (seg_old) begin
                        action_next = srat_pkg::ACT_ACK;
                    end else if (seg_fits) begin
                        ram_re    = 1'b1;
                        ram_raddr = seq_word;
                        word_next = seq_word;
                        last_next = seg_endm1[AW+5:6];
                    end
                end
            end
            srat_pkg::ST_CHK: begin
                if (!first_marked) begin
                    store_next = 1'b1;
                end
            end
            srat_pkg::ST_MARK: begin
                ram_we = 1'b1;
                if (word_reg != last_reg) begin
                    ram_re    = 1'b1;
                    word_next = word_reg + AW'(1);
                end
            end
            srat_pkg::ST_SCAN0: begin
                ram_re    = 1'b1;
                ram_raddr = ne_reg[AW+5:6];
                word_next = ne_reg[AW+5:6];
            end
            srat_pkg::ST_SCAN: begin
                if (ones_cnt == 7'd64 - 7'(ne_off)) begin
                    ne_next   = NE_W'((NE_W'(word_reg) + NE_W'(1)) << 6);
                    ram_re    = 1'b1;
                    word_next = word_reg + AW'(1);
                end else begin
                    ne_next = ne_reg + NE_W'(ones_cnt);
                end
                if (ones_cnt != 7'd0) begin
                    action_next = srat_pkg::ACT_ACK;
                    lp_next     = item_reg.now_ticks;
                end
            end
            srat_pkg::ST_FIN: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= srat_pkg::ST_CLEAR;
            timeout_reg <= 64'd0;
            magic_reg   <= 32'd0;
            flag_reg    <= 8'd0;
            ne_reg      <= '0;
            he_reg      <= 33'd0;
            lp_reg      <= 64'd0;
            lr_reg      <= 64'd0;
            hs_reg      <= 1'b0;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            ne_reg    <= ne_next;
            he_reg    <= he_next;
            lp_reg    <= lp_next;
            lr_reg    <= lr_next;
            hs_reg    <= hs_next;
            clr_reg   <= clr_next;
            if (cfg_valid) begin
                case (cfg_index)
                    srat_pkg::REG_RESEND_TIMEOUT: timeout_reg <= cfg_data;
                    srat_pkg::REG_EXPECTED_MAGIC: magic_reg   <= cfg_data[31:0];
                    srat_pkg::REG_DATA_FLAG_CODE: flag_reg    <= cfg_data[7:0];
                    default: begin
                    end
                endcase
            end
            if (state_reg == srat_pkg::ST_FIN && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        action_reg <= action_next;
        store_reg  <= store_next;
        word_reg   <= word_next;
        last_reg   <= last_next;
        if (s_valid && s_ready) begin
            item_reg <= s_data;
        end
        if (state_reg == srat_pkg::ST_FIN && out_free) begin
            out_reg.action        <= action_reg;
            out_reg.ack_seq       <= (action_reg != srat_pkg::ACT_NONE) ? 17'(ne_reg) : 17'd0;
            out_reg.store_payload <= store_reg;
            out_reg.in_order_end  <= 17'(ne_reg);
        end
    end

endmodule
`default_nettype wire
